FILE: sv/tpds_pkg.sv
// Package for the timer period divider search: widths, lane types and
// prescaler lane helpers. No dependencies.
`default_nettype none
package tpds_pkg;

  localparam int unsigned FREQ_W            = 32;
  localparam int unsigned TARGET_W          = 21;  // freq / 4000 < 2**21
  localparam int unsigned ERR_W             = TARGET_W + 1;
  localparam int unsigned PERIOD_W          = 8;
  localparam int unsigned POST_W            = 4;
  localparam int unsigned PRE_LANES         = 3;
  localparam int unsigned POST_STEPS_DEF    = 16;
  localparam int unsigned PERIOD_COUNTS_DEF = 256;

  typedef enum logic [1:0] {
    PRE_DIV1  = 2'd0,
    PRE_DIV4  = 2'd1,
    PRE_DIV16 = 2'd2
  } prescale_t;

  // Best candidate seen so far for one prescaler ratio.
  typedef struct packed {
    logic [ERR_W-1:0]    err;
    logic [PERIOD_W-1:0] period;
    logic [POST_W-1:0]   post;
  } lane_best_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic [TARGET_W-1:0]             target;
    lane_best_t [PRE_LANES-1:0]      lane;
  } cell_bus_t;

  // Lanes run in search order: 1:16, then 1:4, then 1:1.
  function automatic int unsigned lane_shift(input int unsigned j);
    case (j)
      0:       lane_shift = 4;
      1:       lane_shift = 2;
      default: lane_shift = 0;
    endcase
  endfunction

  function automatic int unsigned lane_ratio(input int unsigned j);
    lane_ratio = 1 << lane_shift(j);
  endfunction

  function automatic prescale_t lane_code(input int unsigned j);
    case (j)
      0:       lane_code = PRE_DIV16;
      1:       lane_code = PRE_DIV4;
      default: lane_code = PRE_DIV1;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: sv/tpds_freq_if.sv
// Request channel carrying one oscillator frequency.
// Depends on tpds_pkg for the field width.
`default_nettype none
interface tpds_freq_if import tpds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] osc_freq_hz;

  modport source (output valid, output osc_freq_hz, input ready);
  modport sink   (input valid, input osc_freq_hz, output ready);
endinterface
`default_nettype wire

FILE: sv/tpds_result_if.sv
// Result channel carrying the chosen timer settings.
// Depends on tpds_pkg for the field widths.
`default_nettype none
interface tpds_result_if import tpds_pkg::*;;
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period_value;
  logic [1:0]          prescale_sel;
  logic [POST_W-1:0]   postscale_sel;

  modport source (output valid, output period_value, output prescale_sel,
                  output postscale_sel, input ready);
  modport sink   (input valid, input period_value, input prescale_sel,
                  input postscale_sel, output ready);
endinterface
`default_nettype wire

FILE: sv/timer_period_divider_search.sv
// Timer period divider search, top level. Depends on tpds_pkg, tpds_front,
// tpds_cell and the two channel interfaces.
//
// Usage:
//   freq   - request channel, one oscillator frequency in hertz per request.
//   result - one result per request: period register value, prescaler code
//            (0 = 1:1, 1 = 1:4, 2 = 1:16) and postscaler ratio minus one.
// The block picks the prescaler/period/postscaler combination whose product
// lands closest to freq / 4000 instruction cycles (a zero target counts as
// one). When nothing fits, it returns period 255 with both scalers at 1:1.
//
// The pipeline runs the divide by 4000, then in each postscaler cell a
// reciprocal multiply followed by candidate scoring, then the output
// register. Every stage is registered and the whole chain moves together,
// so one request is taken per cycle while no result waits on a stall.
// When the receiver stalls with a result waiting, the chain holds and ready
// drops; it rises again the cycle the result is taken.
// Reset clears every valid bit; no result is pending after reset.
`default_nettype none
module timer_period_divider_search import tpds_pkg::*; #(
  parameter int unsigned POST_STEPS    = POST_STEPS_DEF,
  parameter int unsigned PERIOD_COUNTS = PERIOD_COUNTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tpds_freq_if.sink      freq,
  tpds_result_if.source  result
);

  logic      en;
  logic      chain_valid [POST_STEPS+1];
  cell_bus_t chain_bus   [POST_STEPS+1];

  // Advance the whole chain unless a result is stuck at the output.
  assign en         = !result.valid || result.ready;
  assign freq.ready = en;

  tpds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (freq.valid),
    .freq      (freq.osc_freq_hz),
    .out_valid (chain_valid[0]),
    .bus_out   (chain_bus[0])
  );

  // One cell per postscaler ratio, in ascending order.
  for (genvar c = 0; c < POST_STEPS; c++) begin : g_cell
    tpds_cell #(
      .Q             (c + 1),
      .PERIOD_COUNTS (PERIOD_COUNTS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[c]),
      .bus_in    (chain_bus[c]),
      .out_valid (chain_valid[c+1]),
      .bus_out   (chain_bus[c+1])
    );
  end

  // Merge the three lanes in search order; an empty lane keeps the fallback.
  logic [ERR_W-1:0]    pick_err;
  logic [PERIOD_W-1:0] pick_period;
  prescale_t           pick_pre;
  logic [POST_W-1:0]   pick_post;

  always_comb begin
    pick_err    = '1;
    pick_period = '1;
    pick_pre    = PRE_DIV1;
    pick_post   = '0;
    for (int unsigned j = 0; j < PRE_LANES; j++) begin
      if (chain_bus[POST_STEPS].lane[j].err < pick_err) begin
        pick_err    = chain_bus[POST_STEPS].lane[j].err;
        pick_period = chain_bus[POST_STEPS].lane[j].period;
        pick_pre    = lane_code(j);
        pick_post   = chain_bus[POST_STEPS].lane[j].post;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= chain_valid[POST_STEPS];
    end
  end

  // Hold the result payload while the receiver stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      result.period_value  <= pick_period;
      result.prescale_sel  <= pick_pre;
      result.postscale_sel <= pick_post;
    end
  end

endmodule
`default_nettype wire

FILE: sv/tpds_front.sv
// Front end: divides the frequency by 4000 over two stages and seeds empty lanes.
// Depends on tpds_pkg.
`default_nettype none
module tpds_front import tpds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [FREQ_W-1:0] freq,
  output logic              out_valid,
  output cell_bus_t         bus_out
);

  // freq / 4000 = (freq >> 5) / 125; reciprocal exact for 27-bit dividends.
  localparam int unsigned X_W      = FREQ_W - 5;
  localparam int unsigned M_SHIFT  = X_W + 7;
  localparam int unsigned M_W      = 28;
  localparam logic [M_W-1:0] DIV_M = M_W'(((64'd1 << M_SHIFT) + 64'd124) / 64'd125);
  localparam int unsigned PROD_W   = X_W + M_W;

  logic              v1;
  logic [PROD_W-1:0] prod1;
  logic [TARGET_W-1:0] target;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_comb begin
    target = TARGET_W'(prod1 >> M_SHIFT);
    if (target == '0) begin
      target = TARGET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1          <= PROD_W'(freq[FREQ_W-1:5]) * PROD_W'(DIV_M);
      bus_out.target <= target;
      for (int j = 0; j < PRE_LANES; j++) begin
        bus_out.lane[j].err    <= '1;
        bus_out.lane[j].period <= '1;
        bus_out.lane[j].post   <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/tpds_cell.sv
// One postscaler cell: divides the target by its ratio, then scores the floor
// and floor+1 counts for every prescaler lane. Depends on tpds_pkg.
`default_nettype none
module tpds_cell import tpds_pkg::*; #(
  parameter int unsigned Q             = 1,
  parameter int unsigned PERIOD_COUNTS = PERIOD_COUNTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  cell_bus_t bus_in,
  output logic      out_valid,
  output cell_bus_t bus_out
);

  localparam int unsigned RECIP_SHIFT = TARGET_W + 5;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(Q) - 64'd1) / 64'(Q));
  localparam int unsigned PROD_W = TARGET_W + RECIP_W;
  localparam int unsigned CNT_W  = $clog2(PERIOD_COUNTS + 1);
  localparam int unsigned WIDE_W = TARGET_W + 1;

  logic                valid_a;
  cell_bus_t           bus_a;
  logic [TARGET_W-1:0] quot_a;
  logic [PROD_W-1:0]   prod;
  cell_bus_t           bus_next;

  assign prod = PROD_W'(bus_in.target) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  // Score candidates in search order; keep the earlier one on equal error.
  always_comb begin
    logic [TARGET_W-1:0] n;
    logic [WIDE_W-1:0]   cnt;
    logic [ERR_W-1:0]    cand;
    logic [ERR_W-1:0]    tgt;
    logic [ERR_W-1:0]    err;
    logic                fits;
    bus_next = bus_a;
    tgt      = ERR_W'(bus_a.target);
    for (int unsigned j = 0; j < PRE_LANES; j++) begin
      n = quot_a >> lane_shift(j);
      for (int unsigned k = 0; k < 2; k++) begin
        cnt  = WIDE_W'(n) + WIDE_W'(k);
        fits = (cnt != '0) && (cnt <= WIDE_W'(PERIOD_COUNTS));
        cand = ERR_W'(cnt[CNT_W-1:0]) * ERR_W'(lane_ratio(j) * Q);
        err  = (cand >= tgt) ? (cand - tgt) : (tgt - cand);
        if (fits && (err < bus_next.lane[j].err)) begin
          bus_next.lane[j].err    = err;
          bus_next.lane[j].period = PERIOD_W'(cnt - WIDE_W'(1));
          bus_next.lane[j].post   = POST_W'(Q - 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bus_a   <= bus_in;
      quot_a  <= TARGET_W'(prod >> RECIP_SHIFT);
      bus_out <= bus_next;
    end
  end

endmodule
`default_nettype wire
